// ----- rtl/som_bmu_pkg.sv -----
package som_bmu_pkg;

  localparam int CompW   = 16;
  localparam int SqW     = 2 * CompW;
  localparam int DistW   = SqW + 1;
  localparam int PosW    = 4;
  localparam int LabelW  = 16;
  localparam int SizeW   = 7;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 5;

  localparam logic [CfgIdxW-1:0]  CfgMapWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0]  CfgMapHeight = 1'b1;
  localparam logic [CfgDataW-1:0] SizeReset    = 5'd16;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // one beat moving down the cell chain
  typedef struct packed {
    logic              vld;
    logic              query;
    logic              wr;
    logic [PosW-1:0]   pos_x;
    logic [PosW-1:0]   pos_y;
    logic [CompW-1:0]  comp_a;
    logic [CompW-1:0]  comp_b;
    logic [LabelW-1:0] label;
  } beat_t;

  // running best match that travels with a query beat
  typedef struct packed {
    logic              have;
    logic [DistW-1:0]  sq_dist;
    logic [PosW-1:0]   x;
    logic [PosW-1:0]   y;
    logic [LabelW-1:0] label;
  } best_t;

  // effective grid size shared by all cells
  typedef struct packed {
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
  } grid_t;

endpackage

// ----- rtl/som_bmu_if.sv -----
interface som_bmu_in_if;
  import som_bmu_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PosW-1:0]   pos_x;
  logic [PosW-1:0]   pos_y;
  logic [CompW-1:0]  comp_a;
  logic [CompW-1:0]  comp_b;
  logic [LabelW-1:0] label_in;

  modport source (output valid, cmd, pos_x, pos_y, comp_a, comp_b, label_in, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, comp_a, comp_b, label_in, output ready);
endinterface

interface som_bmu_out_if;
  import som_bmu_pkg::*;

  logic              valid;
  logic              ready;
  logic [PosW-1:0]   win_x;
  logic [PosW-1:0]   win_y;
  logic [LabelW-1:0] win_label;
  logic [DistW-1:0]  win_distance;

  modport source (output valid, win_x, win_y, win_label, win_distance, input ready);
  modport sink   (input valid, win_x, win_y, win_label, win_distance, output ready);
endinterface

// ----- rtl/som_bmu_cell.sv -----
module som_bmu_cell #(
  parameter int XPos = 0,
  parameter int YPos = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  som_bmu_pkg::grid_t grid_i,
  input  som_bmu_pkg::beat_t beat_i,
  input  som_bmu_pkg::best_t best_i,
  output som_bmu_pkg::beat_t beat_o,
  output som_bmu_pkg::best_t best_o
);
  import som_bmu_pkg::*;

  // only positions reachable by the 4-bit load fields can be written
  localparam bit              Loadable = (XPos < (1 << PosW)) && (YPos < (1 << PosW));
  localparam logic [PosW-1:0] XCode    = PosW'(XPos);
  localparam logic [PosW-1:0] YCode    = PosW'(YPos);
  localparam logic [SizeW-1:0] XSize   = SizeW'(XPos);
  localparam logic [SizeW-1:0] YSize   = SizeW'(YPos);

  logic [CompW-1:0]  nb_a_q, nb_b_q;
  logic [LabelW-1:0] nb_lbl_q;

  beat_t             beat_q, beat_o_q;
  best_t             best_q, best_o_q, best_d;
  logic [SqW-1:0]    sqa_d, sqb_d, sqa_q, sqb_q;
  logic [LabelW-1:0] lbl_q;
  logic [CompW-1:0]  da, db;
  logic [DistW-1:0]  dist_sum;
  logic              hit, in_grid, take;

  assign hit = beat_i.vld && beat_i.wr && Loadable &&
               (beat_i.pos_x == XCode) && (beat_i.pos_y == YCode);

  assign da    = (nb_a_q >= beat_i.comp_a) ? nb_a_q - beat_i.comp_a : beat_i.comp_a - nb_a_q;
  assign db    = (nb_b_q >= beat_i.comp_b) ? nb_b_q - beat_i.comp_b : beat_i.comp_b - nb_b_q;
  assign sqa_d = SqW'(da) * SqW'(da);
  assign sqb_d = SqW'(db) * SqW'(db);

  // neuron storage, written when its own load beat passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_a_q   <= '0;
      nb_b_q   <= '0;
      nb_lbl_q <= '0;
    end else if (en_i && hit) begin
      nb_a_q   <= beat_i.comp_a;
      nb_b_q   <= beat_i.comp_b;
      nb_lbl_q <= beat_i.label;
    end
  end

  // stage one: squared component differences
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= '0;
    end else if (en_i) begin
      beat_q <= beat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best_q <= best_i;
      sqa_q  <= sqa_d;
      sqb_q  <= sqb_d;
      lbl_q  <= nb_lbl_q;
    end
  end

  // stage two: sum and running minimum, strict compare keeps the earlier tie
  assign dist_sum = DistW'(sqa_q) + DistW'(sqb_q);
  assign in_grid  = (XSize < grid_i.w) && (YSize < grid_i.h);
  assign take     = beat_q.vld && (beat_q.query == CmdQuery) && in_grid &&
                    (!best_q.have || (dist_sum < best_q.sq_dist));

  always_comb begin
    best_d = best_q;
    if (take) begin
      best_d.have    = 1'b1;
      best_d.sq_dist = dist_sum;
      best_d.x       = XCode;
      best_d.y       = YCode;
      best_d.label   = lbl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_o_q <= '0;
    end else if (en_i) begin
      beat_o_q <= beat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best_o_q <= best_d;
    end
  end

  assign beat_o = beat_o_q;
  assign best_o = best_o_q;

endmodule

// ----- rtl/som_best_matching_unit_core.sv -----
// Self-organizing map best matching unit search.
// in_i carries load and query beats; out_o carries one result beat
// per query and nothing for a load. Beats move on valid && ready.
// cfg_we_i / cfg_idx_i / cfg_data_i write map_width (index 0) and
// map_height (index 1); write them only while no beat is in flight.
// The grid is a chain of MAX_WIDTH*MAX_HEIGHT cells, one neuron per cell, in
// scan order (x outer, y inner). Every beat walks the whole chain; each cell
// registers it in a squared-difference stage, then in a sum and running-minimum
// stage, so the chain length sets how long a beat takes to leave. A new beat
// is accepted every cycle while the chain is not held, and loads stay ordered
// with queries because they ride the same chain.
// Reset clears all neurons to zero, empties the chain and sets both grid
// sizes to 16. When the receiver stalls with a result at the chain end, the
// whole chain holds and in_i.ready drops until the result is taken.
module som_best_matching_unit_core #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [som_bmu_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [som_bmu_pkg::CfgDataW-1:0]      cfg_data_i,
  som_bmu_in_if.sink                            in_i,
  som_bmu_out_if.source                         out_o
);
  import som_bmu_pkg::*;

  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [SizeW-1:0] MaxW = SizeW'(MAX_WIDTH);
  localparam logic [SizeW-1:0] MaxH = SizeW'(MAX_HEIGHT);

  logic [CfgDataW-1:0] map_width_q, map_height_q;
  logic [SizeW-1:0]    wreg, hreg;
  grid_t               grid;
  beat_t               beat_chain [Cells+1];
  best_t               best_chain [Cells+1];
  beat_t               beat_in;
  logic                adv, res_vld, load_ok;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= SizeReset;
      map_height_q <= SizeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMapWidth:  map_width_q  <= cfg_data_i;
        CfgMapHeight: map_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective grid: zero acts as one, saturate at the built maximum
  assign wreg = SizeW'(map_width_q);
  assign hreg = SizeW'(map_height_q);

  always_comb begin
    grid.w = (wreg == '0) ? SizeW'(1) : ((wreg > MaxW) ? MaxW : wreg);
    grid.h = (hreg == '0) ? SizeW'(1) : ((hreg > MaxH) ? MaxH : hreg);
  end

  // drop a load outside the effective grid here, once
  assign load_ok = (SizeW'(in_i.pos_x) < grid.w) && (SizeW'(in_i.pos_y) < grid.h);

  always_comb begin
    beat_in.vld    = in_i.valid;
    beat_in.query  = in_i.cmd;
    beat_in.wr     = (in_i.cmd == CmdLoad) && load_ok;
    beat_in.pos_x  = in_i.pos_x;
    beat_in.pos_y  = in_i.pos_y;
    beat_in.comp_a = in_i.comp_a;
    beat_in.comp_b = in_i.comp_b;
    beat_in.label  = in_i.label_in;
  end

  assign beat_chain[0] = beat_in;
  assign best_chain[0] = '0;

  // advance the chain unless a result waits at the end
  assign res_vld    = beat_chain[Cells].vld && (beat_chain[Cells].query == CmdQuery);
  assign adv        = !res_vld || out_o.ready;
  assign in_i.ready = adv;

  for (genvar gx = 0; gx < MAX_WIDTH; gx++) begin : g_col
    for (genvar gy = 0; gy < MAX_HEIGHT; gy++) begin : g_row
      localparam int K = gx * MAX_HEIGHT + gy;
      som_bmu_cell #(
        .XPos(gx),
        .YPos(gy)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (adv),
        .grid_i (grid),
        .beat_i (beat_chain[K]),
        .best_i (best_chain[K]),
        .beat_o (beat_chain[K+1]),
        .best_o (best_chain[K+1])
      );
    end
  end

  // the last cell stage doubles as the output register
  assign out_o.valid        = res_vld;
  assign out_o.win_x        = best_chain[Cells].x;
  assign out_o.win_y        = best_chain[Cells].y;
  assign out_o.win_label    = best_chain[Cells].label;
  assign out_o.win_distance = best_chain[Cells].sq_dist;

endmodule
